/* rtl/core/rfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_pkg - radar frame deframer shared definitions
// Frame layout constants, status codes, register indexes and beat structs.
// ----------------------------------------------------------------------------
package rfd_pkg;

	localparam int HDR_LEN    = 8;
	localparam int OUT_BYTES  = 12;
	localparam int POS_LEN_HI = 3;
	localparam int POS_LEN_LO = 4;
	localparam int POS_TYP_HI = 5;
	localparam int POS_TYP_LO = 6;
	localparam int POS_HDR_CK = 7;

	localparam logic [7:0] CK_GOOD = 8'hFF;

	localparam logic [15:0] TYPE_A13 = 16'h0A13;
	localparam logic [15:0] TYPE_A14 = 16'h0A14;
	localparam logic [15:0] TYPE_A15 = 16'h0A15;
	localparam logic [15:0] TYPE_A16 = 16'h0A16;
	localparam logic [15:0] TYPE_F09 = 16'h0F09;
	localparam logic [15:0] TYPE_FFF = 16'hFFFF;

	localparam logic REG_START_BYTE = 1'b0;
	localparam logic REG_MAX_LEN    = 1'b1;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_SHORT    = 2'd2,
		ST_LENGTH   = 2'd3
	} frame_status_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  rx_byte;
		logic [31:0] now_ms;
	} rfd_step_t;

	typedef struct packed {
		logic          emit;
		frame_status_t frame_status;
		logic [15:0]   frame_type;
		logic [15:0]   payload_length;
		logic [31:0]   payload_word0;
		logic [31:0]   payload_word1;
		logic [31:0]   payload_word2;
		logic [31:0]   frame_time_ms;
		logic [31:0]   valid_frame_count;
		logic [31:0]   checksum_error_count;
		logic [31:0]   parse_error_count;
	} rfd_result_t;

	function automatic logic [15:0] min_len_for(input logic [15:0] t);
		logic [15:0] r;
		unique case (t)
			TYPE_A13: r = 16'd12;
			TYPE_A14: r = 16'd4;
			TYPE_A15: r = 16'd4;
			TYPE_A16: r = 16'd8;
			TYPE_F09: r = 16'd1;
			TYPE_FFF: r = 16'd4;
			default:  r = 16'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/radar_frame_deframer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// radar_frame_deframer - start-byte framed link deframer
// Hunts for the start byte, checks header and payload inverted-XOR checksums
// and gives one result beat per completed or aborted frame.
// ----------------------------------------------------------------------------
// channel | dir | handshake         | content
// s_      | in  | s_tvalid/s_tready | tdata: rx_byte, now_ms
// m_      | out | m_tvalid/m_tready | tuser: frame_status; tdata: frame fields
// cfg_    | in  | cfg_wr_en         | index 0 start_byte, 1 max_payload_length
//
// One byte per cycle while results are taken; a beat goes input register ->
// parser -> result register.
// A stalled result beat holds the parser and, through it, s_tready.
// Reset clears control state and counters; start byte 0x01, limit 512.
// ----------------------------------------------------------------------------
module radar_frame_deframer #(
	parameter int MAX_PAYLOAD = 512,
	parameter int HEAD_BYTES  = 12
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,   // rx_byte[7:0], now_ms[39:8]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [255:0]      m_tdata,   // frame_type, payload_length, word0..2,
	                                     // frame_time_ms, valid, checksum, parse counts
	output logic [1:0]        m_tuser,   // frame_status
	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_index,
	input  wire logic [9:0]   cfg_data
);
	import rfd_pkg::*;

	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;
	logic [31:0] in_time_s1;
	logic [7:0]  start_byte_q;
	logic [9:0]  max_len_q;
	logic        m_valid_q;
	rfd_result_t res_q;
	rfd_result_t res;
	rfd_step_t   step;
	logic        advance;

	assign advance  = in_valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	assign step.valid   = advance;
	assign step.rx_byte = in_byte_s1;
	assign step.now_ms  = in_time_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= 8'h01;
			max_len_q    <= 10'd512;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_START_BYTE: start_byte_q <= cfg_data[7:0];
				REG_MAX_LEN:    max_len_q    <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata[7:0];
			in_time_s1 <= s_tdata[39:8];
		end
	end

	rfd_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.HEAD_BYTES (HEAD_BYTES)
	) u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.start_byte        (start_byte_q),
		.max_payload_length(max_len_q),
		.res               (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.emit) res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.frame_status;
	assign m_tdata  = {res_q.parse_error_count, res_q.checksum_error_count,
	                   res_q.valid_frame_count, res_q.frame_time_ms,
	                   res_q.payload_word2, res_q.payload_word1, res_q.payload_word0,
	                   res_q.payload_length, res_q.frame_type};

endmodule
`default_nettype wire

/* rtl/core/rfd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_parser - frame parsing state and result formation
// Advances the byte position, header and payload checksums and counters on
// each step beat; forms the result beat when a frame completes or aborts.
// ----------------------------------------------------------------------------
module rfd_parser #(
	parameter int MAX_PAYLOAD = 512,
	parameter int HEAD_BYTES  = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  rfd_pkg::rfd_step_t      step,
	input  wire logic [7:0]         start_byte,
	input  wire logic [9:0]         max_payload_length,
	output rfd_pkg::rfd_result_t    res
);
	import rfd_pkg::*;

	localparam int POS_W = $clog2(HDR_LEN + MAX_PAYLOAD + 1);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [15:0]      len_q, len_n;
	logic [15:0]      typ_q, typ_n;
	logic [7:0]       hx_q, hx_n;
	logic [7:0]       px_q, px_n;
	logic [31:0]      vcnt_q, vcnt_n;
	logic [31:0]      ccnt_q, ccnt_n;
	logic [31:0]      pcnt_q, pcnt_n;
	logic [7:0]       head_q [HEAD_BYTES];
	logic [7:0]       head_n [HEAD_BYTES];

	logic [POS_W-1:0] off;
	logic [31:0]      limit;
	logic             use_words;
	logic [31:0]      cnt_sum;

	assign off     = pos_q - POS_W'(HDR_LEN);
	assign limit   = (32'(max_payload_length) > 32'(MAX_PAYLOAD)) ?
	                 32'(MAX_PAYLOAD) : 32'(max_payload_length);
	assign cnt_sum = vcnt_q + ccnt_q + pcnt_q;

	always_comb begin
		pos_n     = pos_q;
		len_n     = len_q;
		typ_n     = typ_q;
		hx_n      = hx_q;
		px_n      = px_q;
		vcnt_n    = vcnt_q;
		ccnt_n    = ccnt_q;
		pcnt_n    = pcnt_q;
		head_n    = head_q;
		use_words = 1'b0;
		res       = '0;
		if (step.valid) begin
			if (pos_q == '0) begin
				if (step.rx_byte == start_byte) begin
					pos_n = POS_W'(1);
					hx_n  = step.rx_byte;
					px_n  = '0;
					len_n = '0;
					typ_n = '0;
					for (int k = 0; k < HEAD_BYTES; k++) head_n[k] = '0;
				end
			end else begin
				pos_n = pos_q + POS_W'(1);
				if (32'(pos_q) < 32'(HDR_LEN)) begin
					hx_n = hx_q ^ step.rx_byte;
					if (pos_q == POS_W'(POS_LEN_HI)) begin
						len_n = {step.rx_byte, 8'h00};
					end else if (pos_q == POS_W'(POS_LEN_LO)) begin
						len_n = {len_q[15:8], step.rx_byte};
					end else if (pos_q == POS_W'(POS_TYP_HI)) begin
						typ_n = {step.rx_byte, 8'h00};
					end else if (pos_q == POS_W'(POS_TYP_LO)) begin
						typ_n = {typ_q[15:8], step.rx_byte};
					end else if (pos_q == POS_W'(POS_HDR_CK)) begin
						if (32'(len_q) > limit) begin
							pcnt_n           = pcnt_q + 32'd1;
							pos_n            = '0;
							res.emit         = 1'b1;
							res.frame_status = ST_LENGTH;
						end
					end
				end else if (32'(off) < 32'(len_q)) begin
					px_n = px_q ^ step.rx_byte;
					for (int k = 0; k < HEAD_BYTES; k++) begin
						if (32'(off) == 32'(k)) head_n[k] = step.rx_byte;
					end
				end else begin
					pos_n     = '0;
					res.emit  = 1'b1;
					use_words = 1'b1;
					priority if (hx_q != CK_GOOD || (px_q ^ step.rx_byte) != CK_GOOD) begin
						ccnt_n           = ccnt_q + 32'd1;
						res.frame_status = ST_CHECKSUM;
					end else if (len_q < min_len_for(typ_q)) begin
						pcnt_n           = pcnt_q + 32'd1;
						res.frame_status = ST_SHORT;
					end else begin
						vcnt_n           = vcnt_q + 32'd1;
						res.frame_status = ST_VALID;
					end
				end
			end
		end
		res.frame_type           = typ_q;
		res.payload_length       = len_q;
		res.frame_time_ms        = step.now_ms;
		res.valid_frame_count    = vcnt_n;
		res.checksum_error_count = ccnt_n;
		res.parse_error_count    = pcnt_n;
		if (use_words) begin
			res.payload_word0 = {head_q[3], head_q[2], head_q[1], head_q[0]};
			res.payload_word1 = {head_q[7], head_q[6], head_q[5], head_q[4]};
			res.payload_word2 = {head_q[11], head_q[10], head_q[9], head_q[8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			typ_q  <= '0;
			hx_q   <= '0;
			px_q   <= '0;
			vcnt_q <= '0;
			ccnt_q <= '0;
			pcnt_q <= '0;
		end else begin
			pos_q  <= pos_n;
			len_q  <= len_n;
			typ_q  <= typ_n;
			hx_q   <= hx_n;
			px_q   <= px_n;
			vcnt_q <= vcnt_n;
			ccnt_q <= ccnt_n;
			pcnt_q <= pcnt_n;
		end
	end

	always_ff @(posedge clk) begin
		head_q <= head_n;
	end

	a_one_count_per_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |=> cnt_sum == $past(cnt_sum) + 32'd1)
		else $error("counter total did not advance by one on a result");

	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!res.emit |=> cnt_sum == $past(cnt_sum))
		else $error("counters moved without a result");

	a_back_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |=> pos_q == '0)
		else $error("not hunting after a result");

	a_len_err_no_words: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit && res.frame_status == ST_LENGTH |->
		res.payload_word0 == '0 && res.payload_word1 == '0 && res.payload_word2 == '0)
		else $error("length error carries payload words");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= 32'(HDR_LEN + MAX_PAYLOAD))
		else $error("byte position past the longest frame");

endmodule
`default_nettype wire

/* verif/tb_radar_frame_deframer.sv */
// ----------------------------------------------------------------------------
// tb_radar_frame_deframer - testbench for the radar frame deframer
// Feeds byte streams of framed, broken and noise traffic through the stream
// input under random idling and back-pressure, predicts every result beat
// from an in-bench deframer and compares all fields in order.
// ----------------------------------------------------------------------------
module tb_radar_frame_deframer;
	import rfd_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int DRAIN_CYCLES = 16;
	localparam int LEN_CAP      = 512;
	localparam int REPORT_MAX   = 10;
	localparam int RANDOM_ITEMS = 460;
	localparam int PHASE_ITEMS  = 115;

	localparam int PAT_RANDOM = 0;
	localparam int PAT_START  = 1;
	localparam int PAT_ONES   = 2;
	localparam int PAT_ZEROS  = 3;

	typedef struct {
		frame_status_t status;
		logic [15:0]   ftype;
		logic [15:0]   flen;
		logic [31:0]   word0;
		logic [31:0]   word1;
		logic [31:0]   word2;
		logic [31:0]   stamp;
		logic [31:0]   good_cnt;
		logic [31:0]   bad_ck_cnt;
		logic [31:0]   parse_cnt;
	} frame_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [255:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_wr_en = 1'b0;
	logic         cfg_index = 1'b0;
	logic [9:0]   cfg_data = '0;

	radar_frame_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// deframer state mirrored in the bench
	logic [7:0]  cfg_start = 8'h01;
	logic [9:0]  cfg_max_len = 10'd512;
	int          rx_pos = 0;
	logic [15:0] hdr_len = '0;
	logic [15:0] hdr_type = '0;
	logic [7:0]  hdr_xor = '0;
	logic [7:0]  body_xor = '0;
	logic [7:0]  head_bytes [OUT_BYTES];
	logic [31:0] good_frames = '0;
	logic [31:0] bad_ck_frames = '0;
	logic [31:0] parse_frames = '0;

	frame_result_t pending_frames [$];

	int  mismatch_count = 0;
	int  items_sent = 0;
	int  cycle_count = 0;
	int  holdoff_left = 0;
	bit  steady = 1'b0;
	bit  use_fixed_ts = 1'b0;
	logic [31:0] fixed_ts = '0;

	function automatic int length_limit();
		return (cfg_max_len > LEN_CAP) ? LEN_CAP : int'(cfg_max_len);
	endfunction

	function automatic int type_min_len(input logic [15:0] t);
		case (t)
			TYPE_A13: return 12;
			TYPE_A14, TYPE_A15, TYPE_FFF: return 4;
			TYPE_A16: return 8;
			TYPE_F09: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic logic [31:0] head_word(input int base);
		return {head_bytes[base + 3], head_bytes[base + 2], head_bytes[base + 1],
			head_bytes[base]};
	endfunction

	task automatic push_frame(input frame_status_t st, input logic [31:0] ts,
		input bit with_words);
		frame_result_t r;
		begin
			r.status     = st;
			r.ftype      = hdr_type;
			r.flen       = hdr_len;
			r.word0      = with_words ? head_word(0) : 32'h0;
			r.word1      = with_words ? head_word(4) : 32'h0;
			r.word2      = with_words ? head_word(8) : 32'h0;
			r.stamp      = ts;
			r.good_cnt   = good_frames;
			r.bad_ck_cnt = bad_ck_frames;
			r.parse_cnt  = parse_frames;
			pending_frames.push_back(r);
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b, input logic [31:0] ts);
		int idx;
		begin
			if (rx_pos == 0) begin
				if (b == cfg_start) begin
					rx_pos   = 1;
					hdr_xor  = b;
					body_xor = '0;
					hdr_len  = '0;
					hdr_type = '0;
					for (int i = 0; i < OUT_BYTES; i++) head_bytes[i] = '0;
				end
			end else begin
				idx = rx_pos;
				rx_pos++;
				if (idx < HDR_LEN) begin
					hdr_xor ^= b;
					case (idx)
						POS_LEN_HI: hdr_len = {b, 8'h00};
						POS_LEN_LO: hdr_len[7:0] = b;
						POS_TYP_HI: hdr_type = {b, 8'h00};
						POS_TYP_LO: hdr_type[7:0] = b;
						POS_HDR_CK: begin
							if (int'(hdr_len) > length_limit()) begin
								parse_frames++;
								rx_pos = 0;
								push_frame(ST_LENGTH, ts, 1'b0);
							end
						end
						default: ;
					endcase
				end else if (idx < HDR_LEN + int'(hdr_len)) begin
					body_xor ^= b;
					if (idx - HDR_LEN < OUT_BYTES) head_bytes[idx - HDR_LEN] = b;
				end else begin
					rx_pos = 0;
					if (hdr_xor != CK_GOOD || (body_xor ^ b) != CK_GOOD) begin
						bad_ck_frames++;
						push_frame(ST_CHECKSUM, ts, 1'b1);
					end else if (int'(hdr_len) < type_min_len(hdr_type)) begin
						parse_frames++;
						push_frame(ST_SHORT, ts, 1'b1);
					end else begin
						good_frames++;
						push_frame(ST_VALID, ts, 1'b1);
					end
				end
			end
		end
	endtask

	// result checking
	task automatic check_field(input string name, input logic [31:0] exp,
		input logic [31:0] act);
		if (exp !== act) begin
			if (mismatch_count < REPORT_MAX)
				$display("mismatch in %s: expected %h, got %h", name, exp, act);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		frame_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_frames.size() == 0) begin
				if (mismatch_count < REPORT_MAX)
					$display("unexpected result beat: status %0d type %h", m_tuser,
						m_tdata[15:0]);
				mismatch_count++;
			end else begin
				e = pending_frames.pop_front();
				check_field("frame_status", 32'(e.status), 32'(m_tuser));
				check_field("frame_type", 32'(e.ftype), 32'(m_tdata[15:0]));
				check_field("payload_length", 32'(e.flen), 32'(m_tdata[31:16]));
				check_field("payload_word0", e.word0, m_tdata[63:32]);
				check_field("payload_word1", e.word1, m_tdata[95:64]);
				check_field("payload_word2", e.word2, m_tdata[127:96]);
				check_field("frame_time_ms", e.stamp, m_tdata[159:128]);
				check_field("valid_frame_count", e.good_cnt, m_tdata[191:160]);
				check_field("checksum_error_count", e.bad_ck_cnt, m_tdata[223:192]);
				check_field("parse_error_count", e.parse_cnt, m_tdata[255:224]);
			end
		end
	end

	// receiver side
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			m_tready = 1'b0;
			holdoff_left--;
		end else if (steady) begin
			m_tready = 1'b1;
		end else begin
			m_tready = ($urandom_range(99) >= 31);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// sender side
	function automatic logic [31:0] next_stamp();
		return use_fixed_ts ? fixed_ts : $urandom;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic [31:0] ts);
		begin
			@(negedge clk);
			while (!steady && $urandom_range(99) < 31) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
			s_tvalid = 1'b1;
			s_tdata  = {ts, b};
			do @(posedge clk); while (!s_tready);
			deframe_byte(b, ts);
			items_sent++;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [9:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == REG_START_BYTE) cfg_start = val[7:0];
		else cfg_max_len = val;
	endtask

	function automatic logic [7:0] fill_byte(input int pat);
		case (pat)
			PAT_START: return cfg_start;
			PAT_ONES:  return 8'hFF;
			PAT_ZEROS: return 8'h00;
			default:   return 8'($urandom);
		endcase
	endfunction

	// cut < 0 sends the whole frame, otherwise only its first cut bytes
	task automatic send_frame(input logic [15:0] len, input logic [15:0] ftype,
		input bit bad_hdr, input bit bad_body, input int pat, input int cut);
		logic [7:0] seq [$];
		logic [7:0] x;
		logic [7:0] p;
		int n;
		begin
			seq.push_back(cfg_start);
			seq.push_back(8'($urandom));
			seq.push_back(8'($urandom));
			seq.push_back(len[15:8]);
			seq.push_back(len[7:0]);
			seq.push_back(ftype[15:8]);
			seq.push_back(ftype[7:0]);
			x = '0;
			foreach (seq[i]) x ^= seq[i];
			seq.push_back(~x ^ (bad_hdr ? 8'($urandom_range(1, 255)) : 8'h00));
			if (int'(len) <= length_limit()) begin
				x = '0;
				for (int i = 0; i < int'(len); i++) begin
					p = fill_byte(pat);
					x ^= p;
					seq.push_back(p);
				end
				seq.push_back(~x ^ (bad_body ? 8'($urandom_range(1, 255)) : 8'h00));
			end
			n = (cut >= 0 && cut < seq.size()) ? cut : seq.size();
			for (int i = 0; i < n; i++) send_byte(seq[i], next_stamp());
		end
	endtask

	task automatic send_noise(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			do b = 8'($urandom); while (b == cfg_start);
			send_byte(b, next_stamp());
		end
	endtask

	function automatic logic [15:0] pick_type();
		case ($urandom_range(6))
			0: return TYPE_A13;
			1: return TYPE_A14;
			2: return TYPE_A15;
			3: return TYPE_A16;
			4: return TYPE_F09;
			5: return TYPE_FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_len();
		int r;
		int l;
		r = $urandom_range(99);
		if (r < 85) l = $urandom_range(0, 16);
		else if (r < 97) l = $urandom_range(17, 64);
		else l = $urandom_range(65, LEN_CAP);
		return 16'((l > length_limit()) ? length_limit() : l);
	endfunction

	// tests
	task automatic test_defaults();
		send_noise(4);
		send_frame(16'd3, 16'h1234, 0, 0, PAT_RANDOM, -1);
		send_frame(16'd0, 16'h0000, 0, 0, PAT_RANDOM, -1);
		use_fixed_ts = 1'b1;
		fixed_ts = 32'h0000_0000;
		send_frame(16'd12, 16'h7777, 0, 0, PAT_ONES, -1);
		fixed_ts = 32'hFFFF_FFFF;
		send_frame(16'd13, 16'hFFFE, 0, 0, PAT_ZEROS, -1);
		use_fixed_ts = 1'b0;
		wait_idle();
	endtask

	task automatic test_length_limit();
		send_frame(16'd513, TYPE_A13, 0, 0, PAT_RANDOM, -1);
		send_frame(16'hFFFF, TYPE_FFF, 0, 0, PAT_RANDOM, -1);
		wait_idle();
		write_reg(REG_MAX_LEN, 10'd0);
		send_frame(16'd0, 16'h4242, 0, 0, PAT_RANDOM, -1);
		send_frame(16'd1, TYPE_F09, 0, 0, PAT_RANDOM, -1);
		wait_idle();
		write_reg(REG_MAX_LEN, 10'd20);
		send_frame(16'd20, TYPE_A16, 0, 0, PAT_RANDOM, -1);
		send_frame(16'd21, TYPE_A16, 0, 0, PAT_RANDOM, -1);
		wait_idle();
		write_reg(REG_MAX_LEN, 10'd1023);
		send_frame(16'd513, TYPE_A16, 0, 0, PAT_RANDOM, -1);
		wait_idle();
		write_reg(REG_MAX_LEN, 10'd512);
	endtask

	task automatic test_type_minimums();
		logic [15:0] types [6];
		int m;
		begin
			types = '{TYPE_A13, TYPE_A14, TYPE_A15, TYPE_A16, TYPE_F09, TYPE_FFF};
			foreach (types[i]) begin
				m = type_min_len(types[i]);
				send_frame(16'(m - 1), types[i], 0, 0, PAT_RANDOM, -1);
				send_frame(16'(m), types[i], 0, 0, PAT_RANDOM, -1);
			end
			wait_idle();
		end
	endtask

	task automatic test_checksums();
		send_frame(16'd6, 16'h0100, 1, 0, PAT_RANDOM, -1);
		send_frame(16'd6, 16'h0100, 0, 1, PAT_RANDOM, -1);
		send_frame(16'd2, TYPE_A13, 1, 0, PAT_RANDOM, -1);
		send_frame(16'd0, 16'h0055, 0, 1, PAT_RANDOM, -1);
		wait_idle();
	endtask

	task automatic test_start_byte();
		write_reg(REG_START_BYTE, 10'h000);
		send_noise(3);
		send_frame(16'd9, TYPE_A16, 0, 0, PAT_START, -1);
		wait_idle();
		write_reg(REG_START_BYTE, 10'h0FF);
		send_frame(16'd14, TYPE_A13, 0, 0, PAT_START, -1);
		send_frame(16'd5, TYPE_A14, 0, 0, PAT_RANDOM, 6);
		send_frame(16'd4, TYPE_A15, 0, 0, PAT_RANDOM, -1);
		send_frame(16'd4, TYPE_A15, 0, 0, PAT_RANDOM, -1);
		wait_idle();
		write_reg(REG_START_BYTE, 10'h001);
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		holdoff_left = 300;
		for (int i = 0; i < 20; i++) send_frame(16'd0, 16'h0000, 0, 0, PAT_RANDOM, -1);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int base;
		int phase_start;
		int phase;
		int kind;
		logic [15:0] len;
		begin
			base = items_sent;
			phase_start = items_sent;
			phase = 0;
			while (items_sent - base < RANDOM_ITEMS) begin
				if (items_sent - phase_start >= PHASE_ITEMS) begin
					wait_idle();
					phase++;
					write_reg(REG_START_BYTE, 10'($urandom_range(0, 255)));
					case ($urandom_range(3))
						0: write_reg(REG_MAX_LEN, 10'($urandom_range(0, 64)));
						1: write_reg(REG_MAX_LEN, 10'd512);
						2: write_reg(REG_MAX_LEN, 10'd1023);
						default: write_reg(REG_MAX_LEN, 10'($urandom_range(0, 1023)));
					endcase
					steady = (phase == 2);
					phase_start = items_sent;
				end
				kind = $urandom_range(99);
				len = pick_len();
				if (kind < 70) begin
					send_frame(len, pick_type(), 0, 0, PAT_RANDOM, -1);
				end else if (kind < 80) begin
					send_frame(len, pick_type(), 1, 0, PAT_RANDOM, -1);
				end else if (kind < 88) begin
					send_frame(len, pick_type(), 0, 1, PAT_RANDOM, -1);
				end else if (kind < 93) begin
					send_noise($urandom_range(1, 6));
				end else if (kind < 97) begin
					len = ($urandom_range(1))
						? 16'(length_limit() + 1 + $urandom_range(0, 100))
						: 16'hFFFF - 16'($urandom_range(0, 255));
					send_frame(len, pick_type(), 0, 0, PAT_RANDOM, -1);
				end else begin
					send_frame(len, pick_type(), 0, 0, PAT_RANDOM,
						$urandom_range(1, HDR_LEN + int'(len)));
				end
			end
			steady = 1'b0;
			wait_idle();
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_defaults();
		test_length_limit();
		test_type_minimums();
		test_checksums();
		test_start_byte();
		test_backpressure();
		test_random_traffic();
		if (mismatch_count == 0 && pending_frames.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* radar_frame_deframer.f */
rtl/core/rfd_pkg.sv
rtl/core/rfd_parser.sv
rtl/core/radar_frame_deframer.sv
verif/tb_radar_frame_deframer.sv
